// ===== design/lswc_pkg.sv =====
`default_nettype none
package lswc_pkg;
  localparam int CoordBits = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int QuotBits  = ProdBits;
  localparam int CntBits   = $clog2(ProdBits + 1);
  localparam int PassBits  = 3;
  localparam int MaxPasses = 4;

  localparam logic [3:0] CodeLeft   = 4'd1;
  localparam logic [3:0] CodeRight  = 4'd2;
  localparam logic [3:0] CodeBottom = 4'd4;
  localparam logic [3:0] CodeTop    = 4'd8;

  localparam logic [1:0] RegLeft   = 2'd0;
  localparam logic [1:0] RegBottom = 2'd1;
  localparam logic [1:0] RegRight  = 2'd2;
  localparam logic [1:0] RegTop    = 2'd3;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic mul;
    logic div_start;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic accept_now;
    logic reject_now;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== design/lswc_datapath.sv =====
`default_nettype none
module lswc_datapath (
  input  wire logic                 clk,
  input  wire lswc_pkg::cmd_t       cmd,
  output lswc_pkg::sts_t            sts,
  input  wire lswc_pkg::coord_t     win_l,
  input  wire lswc_pkg::coord_t     win_b,
  input  wire lswc_pkg::coord_t     win_r,
  input  wire lswc_pkg::coord_t     win_t,
  input  wire lswc_pkg::coord_t     in_x1,
  input  wire lswc_pkg::coord_t     in_y1,
  input  wire lswc_pkg::coord_t     in_x2,
  input  wire lswc_pkg::coord_t     in_y2,
  output lswc_pkg::coord_t          res_x1,
  output lswc_pkg::coord_t          res_y1,
  output lswc_pkg::coord_t          res_x2,
  output lswc_pkg::coord_t          res_y2
);
  localparam int DB = lswc_pkg::DiffBits;
  localparam int PB = lswc_pkg::ProdBits;
  localparam int QB = lswc_pkg::QuotBits;
  localparam int CB = lswc_pkg::CoordBits;

  lswc_pkg::coord_t x1_r, y1_r, x2_r, y2_r;
  logic [3:0] c1_r, c2_r;
  logic sel1_r, horiz_r, neg_r;
  lswc_pkg::coord_t base_r, edge_r;
  logic [DB-1:0] ma_r, mb_r, md_r;
  logic [PB-1:0] prod_r;
  logic [DB:0] rem_r;
  logic [QB-1:0] quot_r;
  logic [lswc_pkg::CntBits-1:0] cnt_r;
  logic busy_r;

  function automatic logic [3:0] region(input lswc_pkg::coord_t x, input lswc_pkg::coord_t y,
      input lswc_pkg::coord_t l, input lswc_pkg::coord_t b,
      input lswc_pkg::coord_t r, input lswc_pkg::coord_t t);
    logic [3:0] c;
    c = 4'd0;
    if (x < l) c = c | lswc_pkg::CodeLeft;
    else if (x > r) c = c | lswc_pkg::CodeRight;
    if (y < b) c = c | lswc_pkg::CodeBottom;
    else if (y > t) c = c | lswc_pkg::CodeTop;
    return c;
  endfunction

  logic [3:0] co;
  logic signed [DB-1:0] a_s, b_s, d_s;
  logic use_y;
  assign co = (c1_r != 4'd0) ? c1_r : c2_r;
  assign use_y = (co & (lswc_pkg::CodeTop | lswc_pkg::CodeBottom)) != 4'd0;

  always_comb begin
    lswc_pkg::coord_t ev;
    if ((co & lswc_pkg::CodeTop) != 4'd0) ev = win_t;
    else if ((co & lswc_pkg::CodeBottom) != 4'd0) ev = win_b;
    else if ((co & lswc_pkg::CodeRight) != 4'd0) ev = win_r;
    else ev = win_l;
    if (use_y) begin
      a_s = DB'(x2_r) - DB'(x1_r);
      b_s = DB'(ev) - DB'(y1_r);
      d_s = DB'(y2_r) - DB'(y1_r);
    end else begin
      a_s = DB'(y2_r) - DB'(y1_r);
      b_s = DB'(ev) - DB'(x1_r);
      d_s = DB'(x2_r) - DB'(x1_r);
    end
  end

  lswc_pkg::coord_t edge_nxt;
  always_comb begin
    lswc_pkg::coord_t ev2;
    if ((co & lswc_pkg::CodeTop) != 4'd0) ev2 = win_t;
    else if ((co & lswc_pkg::CodeBottom) != 4'd0) ev2 = win_b;
    else if ((co & lswc_pkg::CodeRight) != 4'd0) ev2 = win_r;
    else ev2 = win_l;
    edge_nxt = ev2;
  end

  logic [DB:0] trial;
  logic [DB:0] rem_sh;
  assign rem_sh = {rem_r[DB-1:0], prod_r[PB-1]};
  assign trial  = rem_sh - {1'b0, md_r};

  logic signed [QB+1:0] sum;
  logic signed [QB+1:0] sq;
  logic signed [CB-1:0] ires;
  localparam logic signed [QB+1:0] Hi = (QB+2)'((64'sd1 <<< (CB-1)) - 1);
  localparam logic signed [QB+1:0] Lo = -(QB+2)'(64'sd1 <<< (CB-1));
  always_comb begin
    sq = neg_r ? -$signed({2'b00, quot_r}) : $signed({2'b00, quot_r});
    if (md_r == '0) sq = '0;
    sum = sq + (QB+2)'(base_r);
    if (sum > Hi) ires = CB'(Hi);
    else if (sum < Lo) ires = CB'(Lo);
    else ires = CB'(sum);
  end

  lswc_pkg::coord_t nx, ny;
  assign nx = horiz_r ? ires : edge_r;
  assign ny = horiz_r ? edge_r : ires;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r <= in_x1; y1_r <= in_y1; x2_r <= in_x2; y2_r <= in_y2;
      c1_r <= region(in_x1, in_y1, win_l, win_b, win_r, win_t);
      c2_r <= region(in_x2, in_y2, win_l, win_b, win_r, win_t);
    end
    if (cmd.setup) begin
      sel1_r  <= (c1_r != 4'd0);
      horiz_r <= use_y;
      base_r  <= use_y ? x1_r : y1_r;
      edge_r  <= edge_nxt;
      ma_r    <= a_s[DB-1] ? DB'(-a_s) : DB'(a_s);
      mb_r    <= b_s[DB-1] ? DB'(-b_s) : DB'(b_s);
      md_r    <= d_s[DB-1] ? DB'(-d_s) : DB'(d_s);
      neg_r   <= (a_s[DB-1] ^ b_s[DB-1]) ^ d_s[DB-1];
    end
    if (cmd.mul) prod_r <= ma_r * mb_r;
    if (cmd.div_start) begin
      rem_r  <= '0;
      quot_r <= '0;
      cnt_r  <= lswc_pkg::CntBits'(PB);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      prod_r <= {prod_r[PB-2:0], 1'b0};
      if (!trial[DB]) begin
        rem_r  <= trial;
        quot_r <= {quot_r[QB-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        quot_r <= {quot_r[QB-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == lswc_pkg::CntBits'(1)) busy_r <= 1'b0;
    end
    if (cmd.update) begin
      if (sel1_r) begin
        x1_r <= nx; y1_r <= ny; c1_r <= region(nx, ny, win_l, win_b, win_r, win_t);
      end else begin
        x2_r <= nx; y2_r <= ny; c2_r <= region(nx, ny, win_l, win_b, win_r, win_t);
      end
    end
    if (cmd.finish) begin
      res_x1 <= x1_r; res_y1 <= y1_r; res_x2 <= x2_r; res_y2 <= y2_r;
    end
  end

  assign sts.accept_now = (c1_r == 4'd0) && (c2_r == 4'd0);
  assign sts.reject_now = (c1_r & c2_r) != 4'd0;
  assign sts.div_done   = !busy_r;
endmodule
`default_nettype wire

// ===== design/lswc_ctrl.sv =====
`default_nettype none
module lswc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                acc_r,
  output lswc_pkg::cmd_t      cmd,
  input  wire lswc_pkg::sts_t sts
);
  lswc_pkg::state_t state_r, state_nxt;
  logic [lswc_pkg::PassBits-1:0] pass_r, pass_nxt;
  logic acc_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lswc_pkg::ST_IDLE;
      pass_r <= '0;
      acc_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r <= pass_nxt;
      acc_r <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    pass_nxt = pass_r;
    acc_nxt = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      lswc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          pass_nxt = '0;
          state_nxt = lswc_pkg::ST_DECIDE;
        end
      end
      lswc_pkg::ST_DECIDE: begin
        if (sts.accept_now || sts.reject_now ||
            pass_r == lswc_pkg::PassBits'(lswc_pkg::MaxPasses)) begin
          state_nxt = lswc_pkg::ST_OUT;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = lswc_pkg::ST_MUL;
        end
      end
      lswc_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = lswc_pkg::ST_DIV;
      end
      lswc_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = lswc_pkg::ST_UPDATE;
        end
      end
      lswc_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        pass_nxt = pass_r + 1'b1;
        state_nxt = lswc_pkg::ST_DECIDE;
      end
      lswc_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          acc_nxt = sts.accept_now;
          out_valid_nxt = 1'b1;
          state_nxt = lswc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lswc_pkg::ST_IDLE;
    endcase
  end

  ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r) else $error("result dropped");
  ast_pass_max: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r <= lswc_pkg::PassBits'(lswc_pkg::MaxPasses)) else $error("pass overrun");
  ast_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == lswc_pkg::ST_IDLE) else $error("load while busy");
endmodule
`default_nettype wire

// ===== design/line_segment_window_clipper_core.sv =====
// channel | ports                                        | direction
// input   | in_valid in_stall in_start_x/y in_end_x/y    | in
// result  | out_valid out_stall out_accepted out_clip_*  | out
// config  | cfg_we cfg_index cfg_data                    | in
// One segment at a time: load, then per clipping pass (up to 4): decide and setup,
// multiply, the 34-step restoring divider, update. No new segment is taken until
// the result for the last one has left ST_OUT; one serial divider serves every pass.
// rst_n is synchronous; the window resets to 0,0 .. 639,479.
// A finished result waits in the output register under out_stall.
`default_nettype none
module line_segment_window_clipper_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [lswc_pkg::CoordBits-1:0]      cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire lswc_pkg::coord_t                    in_start_x,
  input  wire lswc_pkg::coord_t                    in_start_y,
  input  wire lswc_pkg::coord_t                    in_end_x,
  input  wire lswc_pkg::coord_t                    in_end_y,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_accepted,
  output lswc_pkg::coord_t                         out_clip_start_x,
  output lswc_pkg::coord_t                         out_clip_start_y,
  output lswc_pkg::coord_t                         out_clip_end_x,
  output lswc_pkg::coord_t                         out_clip_end_y
);
  lswc_pkg::coord_t wl_r, wb_r, wr_r, wt_r;
  lswc_pkg::coord_t rx1, ry1, rx2, ry2;
  lswc_pkg::cmd_t cmd;
  lswc_pkg::sts_t sts;
  logic acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= lswc_pkg::CoordBits'(0);
      wb_r <= lswc_pkg::CoordBits'(0);
      wr_r <= lswc_pkg::CoordBits'(639);
      wt_r <= lswc_pkg::CoordBits'(479);
    end else if (cfg_we) begin
      case (cfg_index)
        lswc_pkg::RegLeft:   wl_r <= cfg_data;
        lswc_pkg::RegBottom: wb_r <= cfg_data;
        lswc_pkg::RegRight:  wr_r <= cfg_data;
        lswc_pkg::RegTop:    wt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lswc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .acc_r(acc), .cmd, .sts
  );

  lswc_datapath u_dp (
    .clk, .cmd, .sts,
    .win_l(wl_r), .win_b(wb_r), .win_r(wr_r), .win_t(wt_r),
    .in_x1(in_start_x), .in_y1(in_start_y), .in_x2(in_end_x), .in_y2(in_end_y),
    .res_x1(rx1), .res_y1(ry1), .res_x2(rx2), .res_y2(ry2)
  );

  assign out_accepted     = acc;
  assign out_clip_start_x = acc ? rx1 : '0;
  assign out_clip_start_y = acc ? ry1 : '0;
  assign out_clip_end_x   = acc ? rx2 : '0;
  assign out_clip_end_y   = acc ? ry2 : '0;
endmodule
`default_nettype wire
